// ----- rtl/activity_mode_sequencer_macros.svh -----
`ifndef ACTIVITY_MODE_SEQUENCER_MACROS_SVH
`define ACTIVITY_MODE_SEQUENCER_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define AMS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define AMS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ams_pkg.sv -----
package ams_pkg;

    typedef struct packed {
        logic               command;
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
        logic [15:0]        step_ms;
        logic [2:0]         new_activity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  activity;
        logic [31:0] elapsed_ms;
        logic        advanced;
        logic        exit_met;
    } t_out_item;

    typedef struct packed {
        logic [25:0] threshold;
        logic [1:0]  cmp;
        logic [2:0]  sig;
        logic        en;
    } t_slot;

    typedef struct packed {
        t_slot slot1;
        t_slot slot0;
    } t_rule;

    typedef struct packed {
        logic [3:0] grouping;
        logic       seq_on;
        logic       auto_adv;
    } t_ctrl;

    typedef struct packed {
        logic        command;
        logic [2:0]  new_activity;
        logic [15:0] step_ms;
        logic [23:0] abs_x;
        logic [23:0] abs_y;
        logic [23:0] abs_z;
        logic [47:0] sq_x;
        logic [47:0] sq_y;
        logic [47:0] sq_z;
    } t_front;

    typedef enum logic [2:0] {
        SIG_MAG     = 3'd0,
        SIG_ABS_X   = 3'd1,
        SIG_ABS_Y   = 3'd2,
        SIG_ABS_Z   = 3'd3,
        SIG_ELAPSED = 3'd4
    } t_sig;

    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_LE = 2'd1,
        CMP_GT = 2'd2,
        CMP_GE = 2'd3
    } t_cmp;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [2:0] CFG_GROUPING = 3'd4;
    localparam logic [2:0] CFG_SEQ_ON   = 3'd5;
    localparam logic [2:0] CFG_AUTO     = 3'd6;

    localparam t_rule RULE_RESET [4] = '{
        64'd20993,
        64'd1920057,
        64'd360369232250937,
        64'd7680057
    };

    function automatic logic [51:0] thr_sq_f(input logic [25:0] thr);
        logic [51:0] prod;
        prod = 52'(thr) * 52'(thr);
        return prod;
    endfunction

    function automatic logic slot_holds(
        input t_slot       s,
        input logic [51:0] thr_sq,
        input logic [47:0] mag_sq,
        input logic [23:0] ax,
        input logic [23:0] ay,
        input logic [23:0] az,
        input logic [31:0] elapsed
    );
        logic [51:0] val;
        logic [51:0] thr;
        logic        known;
        logic        res;
        val   = '0;
        thr   = 52'(s.threshold);
        known = 1'b1;
        res   = 1'b0;
        case (s.sig)
            SIG_MAG: begin
                val = 52'(mag_sq);
                thr = thr_sq;
            end
            SIG_ABS_X:   val = 52'(ax);
            SIG_ABS_Y:   val = 52'(ay);
            SIG_ABS_Z:   val = 52'(az);
            SIG_ELAPSED: val = 52'(elapsed);
            default:     known = 1'b0;
        endcase
        case (s.cmp)
            CMP_LT:  res = (val < thr);
            CMP_LE:  res = (val <= thr);
            CMP_GT:  res = (val > thr);
            CMP_GE:  res = (val >= thr);
            default: res = 1'b0;
        endcase
        return s.en && known && res;
    endfunction

endpackage

// ----- rtl/ams_cfg.sv -----
module ams_cfg
    import ams_pkg::*;
#(
    parameter int NUM_ACTIVITIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [2:0]  i_index,
    input  logic [63:0] i_data,
    output t_rule       o_rules  [NUM_ACTIVITIES],
    output logic [51:0] o_thr_sq [NUM_ACTIVITIES][2],
    output t_ctrl       o_ctrl
);

    localparam int IDX_W = (NUM_ACTIVITIES > 2) ? 2 : 1;

    t_rule       r_rules  [NUM_ACTIVITIES];
    logic [51:0] r_thr_sq [NUM_ACTIVITIES][2];
    t_ctrl       r_ctrl;
    t_rule       w_wr_rule;

    assign w_wr_rule = t_rule'(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_ACTIVITIES; a++) begin
                r_rules[IDX_W'(a)]     <= RULE_RESET[2'(a)];
                r_thr_sq[IDX_W'(a)][0] <= thr_sq_f(RULE_RESET[2'(a)].slot0.threshold);
                r_thr_sq[IDX_W'(a)][1] <= thr_sq_f(RULE_RESET[2'(a)].slot1.threshold);
            end
            r_ctrl <= '0;
        end else if (i_we) begin
            if (i_index < 3'(NUM_ACTIVITIES)) begin
                r_rules[i_index[IDX_W-1:0]]     <= w_wr_rule;
                r_thr_sq[i_index[IDX_W-1:0]][0] <= thr_sq_f(w_wr_rule.slot0.threshold);
                r_thr_sq[i_index[IDX_W-1:0]][1] <= thr_sq_f(w_wr_rule.slot1.threshold);
            end else begin
                case (i_index)
                    CFG_GROUPING: r_ctrl.grouping <= i_data[3:0];
                    CFG_SEQ_ON:   r_ctrl.seq_on   <= i_data[0];
                    CFG_AUTO:     r_ctrl.auto_adv <= i_data[0];
                    default:      ;
                endcase
            end
        end
    end

    assign o_rules  = r_rules;
    assign o_thr_sq = r_thr_sq;
    assign o_ctrl   = r_ctrl;

endmodule

// ----- rtl/ams_front.sv -----
module ams_front
    import ams_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_valid,
    output t_front   o_data,
    input  logic     i_take
);

    logic   r_vld;
    t_front r_data;
    t_front n_data;

    function automatic logic [23:0] abs24(input logic [23:0] v);
        return v[23] ? (~v + 24'd1) : v;
    endfunction

    always_comb begin
        n_data              = '0;
        n_data.command      = i_data.command;
        n_data.new_activity = i_data.new_activity;
        n_data.step_ms      = i_data.step_ms;
        n_data.abs_x        = abs24(i_data.rate_x);
        n_data.abs_y        = abs24(i_data.rate_y);
        n_data.abs_z        = abs24(i_data.rate_z);
        n_data.sq_x         = 48'(n_data.abs_x) * 48'(n_data.abs_x);
        n_data.sq_y         = 48'(n_data.abs_y) * 48'(n_data.abs_y);
        n_data.sq_z         = 48'(n_data.abs_z) * 48'(n_data.abs_z);
    end

    assign o_ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

// ----- rtl/ams_core.sv -----
module ams_core
    import ams_pkg::*;
#(
    parameter int NUM_ACTIVITIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_front      i_data,
    output logic        o_take,
    input  t_rule       i_rules  [NUM_ACTIVITIES],
    input  logic [51:0] i_thr_sq [NUM_ACTIVITIES][2],
    input  t_ctrl       i_ctrl,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int         IDX_W    = (NUM_ACTIVITIES > 2) ? 2 : 1;
    localparam logic [1:0] LAST_ACT = 2'(NUM_ACTIVITIES - 1);

    logic        r_out_vld;
    t_out_item   r_out;
    logic [1:0]  r_act;
    logic [31:0] r_elapsed;

    logic [1:0]  n_act;
    logic [31:0] n_elapsed;
    t_out_item   n_out;

    logic [32:0] w_sum_el;
    logic [31:0] w_el_add;
    logic [47:0] w_mag_sq;
    t_rule       w_rule;
    logic        w_h0;
    logic        w_h1;
    logic        w_rule_ok;

    assign o_take = !r_out_vld || i_out_ready;

    always_comb begin
        w_sum_el  = {1'b0, r_elapsed} + 33'(i_data.step_ms);
        w_el_add  = w_sum_el[32] ? '1 : w_sum_el[31:0];
        w_mag_sq  = i_data.sq_x + i_data.sq_y + i_data.sq_z;
        w_rule    = i_rules[r_act[IDX_W-1:0]];
        w_h0      = slot_holds(w_rule.slot0, i_thr_sq[r_act[IDX_W-1:0]][0], w_mag_sq,
                               i_data.abs_x, i_data.abs_y, i_data.abs_z, w_el_add);
        w_h1      = slot_holds(w_rule.slot1, i_thr_sq[r_act[IDX_W-1:0]][1], w_mag_sq,
                               i_data.abs_x, i_data.abs_y, i_data.abs_z, w_el_add);
        if (i_ctrl.grouping[r_act]) begin
            w_rule_ok = w_h0 || w_h1;
        end else begin
            w_rule_ok = (w_rule.slot0.en || w_rule.slot1.en)
                        && (!w_rule.slot0.en || w_h0) && (!w_rule.slot1.en || w_h1);
        end

        n_act     = r_act;
        n_elapsed = r_elapsed;
        n_out     = '0;
        if (i_data.command == CMD_SET) begin
            if (i_data.new_activity < 3'(NUM_ACTIVITIES)) begin
                n_act     = i_data.new_activity[1:0];
                n_elapsed = '0;
            end
        end else if (i_ctrl.seq_on) begin
            n_elapsed = w_el_add;
            if (i_ctrl.auto_adv && w_rule_ok) begin
                n_out.advanced = 1'b1;
                n_out.exit_met = 1'b1;
                n_act          = (r_act == LAST_ACT) ? 2'd0 : r_act + 2'd1;
                n_elapsed      = '0;
            end
        end
        n_out.activity   = n_act;
        n_out.elapsed_ms = n_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_act     <= '0;
            r_elapsed <= '0;
        end else if (i_valid && o_take) begin
            r_out_vld <= 1'b1;
            r_act     <= n_act;
            r_elapsed <= n_elapsed;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/activity_mode_sequencer.sv -----
// Cyclic activity sequencer.
// Requests enter on the input channel (i_in_valid / o_in_ready, payload i_in_data).
// With the sequencer on, a tick request adds its time step to the elapsed time and,
// with auto-advance on, checks the exit rule of the current activity; a set request
// jumps to an activity in range. Every request yields exactly one result on the output
// channel (o_out_valid / i_out_ready, payload o_out_data).
// Rule registers, slot grouping and the enable bits are written through the
// configuration channel (i_cfg_valid / o_cfg_ready), always ready; write them only
// while idle, which the block itself does not enforce. The first stage takes rate
// magnitudes and their squares, the second evaluates the rule against the activity
// state and fills the result register. While results are taken, one request is
// accepted every cycle. If the receiver stalls, one result waits in the output
// register and one request waits in the first stage, after which o_in_ready drops
// until a result is taken. Reset returns to the first activity with zero elapsed
// time and loads the default exit rules, with the sequencer and auto-advance off.
module activity_mode_sequencer
    import ams_pkg::*;
#(
    parameter int NUM_ACTIVITIES = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

`include "activity_mode_sequencer_macros.svh"

    t_rule       w_rules  [NUM_ACTIVITIES];
    logic [51:0] w_thr_sq [NUM_ACTIVITIES][2];
    t_ctrl       w_ctrl;
    logic        w_front_vld;
    t_front      w_front;
    logic        w_take;

    assign o_cfg_ready = 1'b1;

    ams_cfg #(
        .NUM_ACTIVITIES(NUM_ACTIVITIES)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (i_cfg_valid && o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_rules  (w_rules),
        .o_thr_sq (w_thr_sq),
        .o_ctrl   (w_ctrl)
    );

    ams_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_front_vld),
        .o_data  (w_front),
        .i_take  (w_take)
    );

    ams_core #(
        .NUM_ACTIVITIES(NUM_ACTIVITIES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_front_vld),
        .i_data      (w_front),
        .o_take      (w_take),
        .i_rules     (w_rules),
        .i_thr_sq    (w_thr_sq),
        .i_ctrl      (w_ctrl),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `AMS_ASSERT_NEXT(a_front_kept, w_front_vld && !w_take, w_front_vld, "request lost in first stage")
    `AMS_ASSERT_IMPL(a_stall_full, !o_in_ready, w_front_vld && o_out_valid, "input stalled while not full")
    `AMS_ASSERT_IMPL(a_adv_enabled, o_out_valid && o_out_data.advanced, w_ctrl.seq_on && w_ctrl.auto_adv, "advance while disabled")
    `AMS_ASSERT_IMPL(a_adv_clears, o_out_valid && o_out_data.advanced, o_out_data.exit_met && (o_out_data.elapsed_ms == 32'd0), "advance without exit and clear")

endmodule

// ----- bench/tb_activity_mode_sequencer.sv -----
module tb_activity_mode_sequencer;
    import ams_pkg::*;

    localparam int ACTIVITIES = 4;
    localparam logic [2:0] CFG_RULE_FIRST = 3'd0;
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;
    localparam logic signed [23:0] RATE_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] RATE_MIN = 24'sh80_0000;
    localparam int LONG_RUN_TICKS = 20;
    localparam int PHASE_CHUNK = 90;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    t_in_item pending_requests[$];
    t_out_item expected_status[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    logic req_taken = 1'b0;

    t_rule rule_set[ACTIVITIES];
    logic [3:0] group_or;
    logic seq_enabled;
    logic auto_enabled;
    logic [1:0] act_now;
    logic [31:0] elapsed_now;

    activity_mode_sequencer #(
        .NUM_ACTIVITIES(ACTIVITIES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [23:0] rate_magnitude(logic signed [23:0] rate);
        logic [23:0] raw;
        raw = rate;
        return raw[23] ? (~raw + 24'd1) : raw;
    endfunction

    function automatic logic slot_condition(t_slot s, logic [23:0] ax, logic [23:0] ay,
                                            logic [23:0] az, logic [31:0] elapsed);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = '0;
        rhs = 64'(s.threshold);
        case (s.sig)
            SIG_MAG: begin
                lhs = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
                rhs = rhs * rhs;
            end
            SIG_ABS_X: lhs = 64'(ax);
            SIG_ABS_Y: lhs = 64'(ay);
            SIG_ABS_Z: lhs = 64'(az);
            SIG_ELAPSED: lhs = 64'(elapsed);
            default: return 1'b0;
        endcase
        case (s.cmp)
            CMP_LT: return lhs < rhs;
            CMP_LE: return lhs <= rhs;
            CMP_GT: return lhs > rhs;
            default: return lhs >= rhs;
        endcase
    endfunction

    function automatic logic exit_rule_holds(logic [23:0] ax, logic [23:0] ay, logic [23:0] az);
        t_rule rule;
        logic h0;
        logic h1;
        rule = rule_set[act_now];
        h0 = rule.slot0.en && slot_condition(rule.slot0, ax, ay, az, elapsed_now);
        h1 = rule.slot1.en && slot_condition(rule.slot1, ax, ay, az, elapsed_now);
        if (group_or[act_now]) begin
            return h0 || h1;
        end
        if (!rule.slot0.en && !rule.slot1.en) begin
            return 1'b0;
        end
        return (!rule.slot0.en || h0) && (!rule.slot1.en || h1);
    endfunction

    // Advances the local copy of the activity state by one request.
    function automatic t_out_item next_activity_status(t_in_item req);
        t_out_item status;
        logic [32:0] sum;
        status = '0;
        if (req.command == CMD_SET) begin
            if (req.new_activity < ACTIVITIES) begin
                act_now = req.new_activity[1:0];
                elapsed_now = '0;
            end
        end else if (seq_enabled) begin
            sum = {1'b0, elapsed_now} + 33'(req.step_ms);
            elapsed_now = sum[32] ? '1 : sum[31:0];
            if (auto_enabled && exit_rule_holds(rate_magnitude(req.rate_x),
                    rate_magnitude(req.rate_y), rate_magnitude(req.rate_z))) begin
                status.exit_met = 1'b1;
                status.advanced = 1'b1;
                act_now = (act_now == ACTIVITIES - 1) ? 2'd0 : act_now + 2'd1;
                elapsed_now = '0;
            end
        end
        status.activity = act_now;
        status.elapsed_ms = elapsed_now;
        return status;
    endfunction

    function automatic void store_register(logic [2:0] idx, logic [63:0] value);
        if (idx < CFG_GROUPING) begin
            rule_set[idx[1:0]] = value;
        end else if (idx == CFG_GROUPING) begin
            group_or = value[3:0];
        end else if (idx == CFG_SEQ_ON) begin
            seq_enabled = value[0];
        end else if (idx == CFG_AUTO) begin
            auto_enabled = value[0];
        end
    endfunction

    task automatic report_field(string field, logic [31:0] want, logic [31:0] seen);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, seen);
        error_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        req_taken = 1'b0;
        if (!i_rst_n) begin
            for (int a = 0; a < ACTIVITIES; a++) begin
                rule_set[a] = RULE_RESET[a];
            end
            group_or = '0;
            seq_enabled = 1'b0;
            auto_enabled = 1'b0;
            act_now = '0;
            elapsed_now = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %p", $time,
                             o_out_data);
                    error_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (o_out_data.activity !== want.activity) begin
                        report_field("activity", want.activity, o_out_data.activity);
                    end
                    if (o_out_data.elapsed_ms !== want.elapsed_ms) begin
                        report_field("elapsed_ms", want.elapsed_ms, o_out_data.elapsed_ms);
                    end
                    if (o_out_data.advanced !== want.advanced) begin
                        report_field("advanced", want.advanced, o_out_data.advanced);
                    end
                    if (o_out_data.exit_met !== want.exit_met) begin
                        report_field("exit_met", want.exit_met, o_out_data.exit_met);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                req_taken = 1'b1;
                expected_status.push_back(next_activity_status(i_in_data));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                store_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        logic next_valid;
        t_in_item next_req;
        next_valid = i_in_valid;
        next_req = i_in_data;
        if (!i_in_valid || req_taken) begin
            next_valid = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                next_valid = 1'b1;
            end
        end
        i_in_valid <= next_valid;
        i_in_data <= next_req;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic signed [23:0] random_rate();
        case ($urandom_range(3))
            0, 1: return 24'(int'($urandom_range(4000)) - 2000);
            2: return 24'(int'($urandom_range(131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in_item tick_request(logic signed [23:0] x, logic signed [23:0] y,
                                              logic signed [23:0] z, logic [15:0] step);
        t_in_item req;
        req.command = CMD_TICK;
        req.rate_x = x;
        req.rate_y = y;
        req.rate_z = z;
        req.step_ms = step;
        req.new_activity = 3'($urandom_range(7));
        return req;
    endfunction

    function automatic t_in_item set_request(logic [2:0] target);
        t_in_item req;
        req = tick_request(random_rate(), random_rate(), random_rate(), 16'($urandom));
        req.command = CMD_SET;
        req.new_activity = target;
        return req;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        logic [15:0] step;
        step = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
        req = tick_request(random_rate(), random_rate(), random_rate(), step);
        if ($urandom_range(99) < 12) begin
            req.command = CMD_SET;
        end
        return req;
    endfunction

    function automatic t_slot make_slot(t_sig sig, t_cmp cmp, logic [25:0] thr);
        t_slot s;
        s.en = 1'b1;
        s.sig = sig;
        s.cmp = cmp;
        s.threshold = thr;
        return s;
    endfunction

    function automatic t_slot random_slot();
        t_slot s;
        s.en = ($urandom_range(4) != 0);
        s.sig = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        s.cmp = 2'($urandom_range(3));
        case (s.sig)
            SIG_MAG: s.threshold = 26'($urandom_range(4000));
            SIG_ELAPSED: s.threshold = 26'($urandom_range(10000));
            default: s.threshold = 26'($urandom_range(3000));
        endcase
        if ($urandom_range(7) == 0) begin
            s.threshold = 26'($urandom);
        end
        return s;
    endfunction

    function automatic logic [63:0] random_rule();
        if ($urandom_range(9) == 0) begin
            return {$urandom, $urandom};
        end
        return {random_slot(), random_slot()};
    endfunction

    task automatic write_register(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_requests.size() != 0 || i_in_valid || expected_status.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [63:0] value;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With the sequencer off a tick changes nothing.
        pending_requests.push_back(tick_request(RATE_MAX, RATE_MAX, RATE_MAX, 16'hFFFF));
        pending_requests.push_back(set_request(3'd5));
        wait_drained();
        write_register(CFG_SEQ_ON, 64'd1);
        write_register(CFG_AUTO, 64'd1);
        write_register(CFG_GROUPING, 64'd0);
        write_register(CFG_UNMAPPED, '1);

        pending_requests.push_back(tick_request(24'sd0, 24'sd0, 24'sd0, 16'd10));
        pending_requests.push_back(tick_request(RATE_MAX, RATE_MIN, RATE_MAX, 16'd29999));
        pending_requests.push_back(tick_request(24'sd0, 24'sd0, 24'sd0, 16'd1));
        pending_requests.push_back(tick_request(RATE_MIN, RATE_MIN, RATE_MIN, 16'd0));
        pending_requests.push_back(tick_request(24'sd100, 24'sd100, 24'sd100, 16'd500));
        pending_requests.push_back(set_request(3'd3));
        pending_requests.push_back(tick_request(24'sd327, 24'sd0, 24'sd0, 16'd5));
        pending_requests.push_back(set_request(3'd3));
        pending_requests.push_back(set_request(3'd4));
        pending_requests.push_back(set_request(3'd7));
        pending_requests.push_back(set_request(3'd0));
        pending_requests.push_back(tick_request(RATE_MIN, 24'sd0, 24'sd0, 16'd0));
        pending_requests.push_back(tick_request(-24'sd328, 24'sd0, 24'sd0, 16'd3));
        pending_requests.push_back(tick_request(24'sd0, -24'sd327, 24'sd0, 16'd3));
        wait_drained();

        // Slot 0 tests |x| <= 1000, slot 1 tests elapsed > 50.
        write_register(CFG_RULE_FIRST, {make_slot(SIG_ELAPSED, CMP_GT, 26'd50),
                                        make_slot(SIG_ABS_X, CMP_LE, 26'd1000)});
        write_register(CFG_GROUPING, 64'd1);
        pending_requests.push_back(set_request(3'd0));
        pending_requests.push_back(tick_request(24'sd1000, RATE_MAX, RATE_MIN, 16'd10));
        pending_requests.push_back(set_request(3'd0));
        pending_requests.push_back(tick_request(24'sd1001, 24'sd0, 24'sd0, 16'd60));
        pending_requests.push_back(set_request(3'd0));
        pending_requests.push_back(tick_request(-24'sd1001, 24'sd0, 24'sd0, 16'd10));
        wait_drained();
        write_register(CFG_GROUPING, 64'd0);
        pending_requests.push_back(tick_request(-24'sd1000, 24'sd0, 24'sd0, 16'd60));
        wait_drained();

        // Let the elapsed time run up with auto-advance off.
        write_register(CFG_AUTO, 64'd0);
        pending_requests.push_back(set_request(3'd0));
        for (int n = 0; n < LONG_RUN_TICKS; n++) begin
            pending_requests.push_back(tick_request(random_rate(), random_rate(),
                                                    random_rate(), 16'hFFFF));
        end
        wait_drained();

        for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < ACTIVITIES; a++) begin
                value = random_rule();
                if (k == 3 && a == 2) begin
                    value = '0;
                end else if (k == 3 && a == 3) begin
                    value = '1;
                end
                write_register(CFG_RULE_FIRST + 3'(a), value);
            end
            if (k == 0) begin
                write_register(CFG_GROUPING, 64'd0);
            end else if (k == 1) begin
                write_register(CFG_GROUPING, 64'd15);
            end else begin
                write_register(CFG_GROUPING, 64'($urandom_range(15)));
            end
            write_register(CFG_SEQ_ON, (k == 5) ? 64'd0 : 64'd1);
            write_register(CFG_AUTO, (k == 6) ? 64'd0 : 64'd1);
            if (k == 2) begin
                write_register(CFG_UNMAPPED, {$urandom, $urandom});
            end
            case (k % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default: begin
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
            endcase
            for (int n = 0; n < PHASE_CHUNK; n++) begin
                pending_requests.push_back(random_request());
            end
            // The sender holds off here until every outstanding request has answered.
            wait_drained();
            for (int n = 0; n < PHASE_CHUNK; n++) begin
                pending_requests.push_back(random_request());
            end
            wait_drained();
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        wait_drained();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ams_pkg.sv
rtl/ams_cfg.sv
rtl/ams_front.sv
rtl/ams_core.sv
rtl/activity_mode_sequencer.sv
bench/tb_activity_mode_sequencer.sv
